@@ hw/rtl/ffwp_pkg.sv @@
package ffwp_pkg;

	// table size default and scan grid pitch
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int GRID_STEP       = 8;

	// field widths
	localparam int DIM_W   = 13;
	localparam int FIELD_W = 16;
	localparam int SUM_W   = 15;
	localparam int PCT_W   = 7;
	localparam int PROD_W  = DIM_W + PCT_W;

	// shrink percentages
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_W-1:0] PCT_STEP = 7'd10;
	localparam logic [PCT_W-1:0] PCT_LAST = 7'd40;

	// divide by 100 as multiply by ceil(2^27 / 100) and shift
	localparam int RECIP_W   = 21;
	localparam int DIV_SHIFT = 27;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 21'd1342178;

	// register reset values
	localparam logic [DIM_W-1:0] SCREEN_W_RST = 13'd1920;
	localparam logic [DIM_W-1:0] SCREEN_H_RST = 13'd1080;
	localparam logic [DIM_W-1:0] MIN_W_RST    = 13'd200;
	localparam logic [DIM_W-1:0] MIN_H_RST    = 13'd120;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_PLACE = 2'd2
	} ffwp_op_t;

	typedef enum logic [1:0] {
		CFG_SCREEN_W = 2'd0,
		CFG_SCREEN_H = 2'd1,
		CFG_MIN_W    = 2'd2,
		CFG_MIN_H    = 2'd3
	} ffwp_cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] screen_width;
		logic [DIM_W-1:0] screen_height;
		logic [DIM_W-1:0] min_width;
		logic [DIM_W-1:0] min_height;
	} ffwp_cfg_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] left;
		logic signed [FIELD_W-1:0] top;
		logic [FIELD_W-1:0]        width;
		logic [FIELD_W-1:0]        height;
	} ffwp_entry_t;

	typedef struct packed {
		logic        en;
		ffwp_entry_t entry;
	} ffwp_wr_t;

	// candidate spot moving down the cell row
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
	} ffwp_cand_t;

endpackage

@@ hw/rtl/ffwp_cell.sv @@
module ffwp_cell
	import ffwp_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int IDX = 0,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ffwp_wr_t         wr,
	input  logic [IW-1:0]    wr_idx,
	input  logic [CW-1:0]    count,
	input  logic [DIM_W-1:0] try_w,
	input  logic [DIM_W-1:0] try_h,
	input  ffwp_cand_t       cand_in,
	output ffwp_cand_t       cand_out
);

	ffwp_entry_t entry_q;
	ffwp_cand_t  cand_q;

	logic              sel;
	logic              active;
	logic              overlap;
	logic signed [17:0] ax, ay, ar, ab, cx, cy, cr, cb;

	assign sel    = wr.en && (wr_idx == IW'(IDX));
	assign active = count > CW'(IDX);

	// half-open overlap of candidate against the stored rectangle
	always_comb begin
		ax = {{2{entry_q.left[FIELD_W-1]}}, entry_q.left};
		ay = {{2{entry_q.top[FIELD_W-1]}}, entry_q.top};
		ar = ax + $signed({2'b00, entry_q.width});
		ab = ay + $signed({2'b00, entry_q.height});
		cx = $signed({5'b0, cand_in.x});
		cy = $signed({5'b0, cand_in.y});
		cr = cx + $signed({5'b0, try_w});
		cb = cy + $signed({5'b0, try_h});
		overlap = (cx < ar) && (ax < cr) && (cy < ab) && (ay < cb);
	end

	// stored rectangle
	always_ff @(posedge clk) begin
		if (sel) begin
			entry_q <= wr.entry;
		end
	end

	// hand the candidate to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q.valid <= cand_in.valid;
			cand_q.hit   <= cand_in.hit || (active && overlap);
			cand_q.x     <= cand_in.x;
			cand_q.y     <= cand_in.y;
		end
	end

	assign cand_out = cand_q;

endmodule

@@ hw/rtl/ffwp_seq.sv @@
module ffwp_seq
	import ffwp_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                op,
	input  logic signed [FIELD_W-1:0] rect_x,
	input  logic signed [FIELD_W-1:0] rect_y,
	input  logic [FIELD_W-1:0]        rect_width,
	input  logic [FIELD_W-1:0]        rect_height,
	input  ffwp_cfg_t                 cfg,
	output logic                      busy,
	output ffwp_wr_t                  wr,
	output logic [IW-1:0]             wr_idx,
	output logic [CW-1:0]             count,
	output logic [DIM_W-1:0]          try_w,
	output logic [DIM_W-1:0]          try_h,
	output ffwp_cand_t                cand_in,
	input  ffwp_cand_t                cand_out,
	output logic [DIM_W-1:0]          place_x,
	output logic [DIM_W-1:0]          place_y,
	output logic [DIM_W-1:0]          place_width,
	output logic [DIM_W-1:0]          place_height,
	output logic                      fits,
	output logic                      table_full,
	output logic                      done
);

	localparam int FW = $clog2(TABLE_DEPTH + 2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_CHECK,
		ST_SCAN
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [PCT_W-1:0]  pct_q;
	logic              gen_done_q;
	logic              found_q;
	logic [FW-1:0]     inflight_q;
	logic [DIM_W-1:0]  px_q, py_q, pw_q, ph_q;
	logic              fits_q, full_q, done_q;

	logic [DIM_W-1:0]  base_w_q, base_h_q;
	logic [PROD_W-1:0] prod_w_q, prod_h_q;
	logic [DIM_W-1:0]  quot_w_q, quot_h_q;
	logic [DIM_W-1:0]  try_w_q, try_h_q;
	logic [DIM_W-1:0]  gx_q, gy_q;
	logic [DIM_W-1:0]  fx_q, fy_q;

	logic                      accept;
	logic                      full;
	logic                      issue;
	logic                      free_hit;
	logic                      scan_end;
	logic [SUM_W-1:0]          nx, ny;
	logic                      x_fit, y_fit;
	logic [DIM_W-1:0]          clamp_w, clamp_h;
	logic [PROD_W+RECIP_W-1:0] quot_w_full, quot_h_full;

	assign accept   = start && (state_q == ST_IDLE);
	assign full     = count_q == CW'(TABLE_DEPTH);
	assign issue    = (state_q == ST_SCAN) && !gen_done_q && !found_q;
	assign free_hit = (state_q == ST_SCAN) && cand_out.valid && !cand_out.hit && !found_q;
	assign scan_end = (state_q == ST_SCAN) && (inflight_q == '0) && (found_q || gen_done_q);

	// next grid spot, along the row then down
	always_comb begin
		nx    = SUM_W'(gx_q) + SUM_W'(GRID_STEP);
		ny    = SUM_W'(gy_q) + SUM_W'(GRID_STEP);
		x_fit = (nx + SUM_W'(try_w_q)) <= SUM_W'(cfg.screen_width);
		y_fit = (ny + SUM_W'(try_h_q)) <= SUM_W'(cfg.screen_height);
	end

	// clamp request to the screen
	always_comb begin
		clamp_w = (rect_width > FIELD_W'(cfg.screen_width)) ? cfg.screen_width
			: rect_width[DIM_W-1:0];
		clamp_h = (rect_height > FIELD_W'(cfg.screen_height)) ? cfg.screen_height
			: rect_height[DIM_W-1:0];
	end

	assign quot_w_full = (PROD_W + RECIP_W)'(prod_w_q) * (PROD_W + RECIP_W)'(DIV_RECIP);
	assign quot_h_full = (PROD_W + RECIP_W)'(prod_h_q) * (PROD_W + RECIP_W)'(DIV_RECIP);

	// table write from an add or from a placed window
	always_comb begin
		wr.en = (accept && (op == OP_ADD) && !full) || (scan_end && found_q && !full);
		if (accept) begin
			wr.entry.left   = rect_x;
			wr.entry.top    = rect_y;
			wr.entry.width  = rect_width;
			wr.entry.height = rect_height;
		end else begin
			wr.entry.left   = $signed(FIELD_W'(fx_q));
			wr.entry.top    = $signed(FIELD_W'(fy_q));
			wr.entry.width  = FIELD_W'(try_w_q);
			wr.entry.height = FIELD_W'(try_h_q);
		end
	end

	assign wr_idx        = count_q[IW-1:0];
	assign count         = count_q;
	assign try_w         = try_w_q;
	assign try_h         = try_h_q;
	assign cand_in.valid = issue;
	assign cand_in.hit   = 1'b0;
	assign cand_in.x     = gx_q;
	assign cand_in.y     = gy_q;

	// control state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			pct_q      <= PCT_FULL;
			gen_done_q <= 1'b0;
			found_q    <= 1'b0;
			inflight_q <= '0;
			px_q       <= '0;
			py_q       <= '0;
			pw_q       <= '0;
			ph_q       <= '0;
			fits_q     <= 1'b0;
			full_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (op)
							OP_CLEAR: begin
								count_q <= '0;
							end
							OP_ADD: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end else begin
									done_q <= 1'b1;
									px_q   <= '0;
									py_q   <= '0;
									pw_q   <= '0;
									ph_q   <= '0;
									fits_q <= 1'b0;
									full_q <= 1'b1;
								end
							end
							OP_PLACE: begin
								pct_q   <= PCT_FULL;
								state_q <= ST_MUL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if ((quot_w_q < cfg.min_width) || (quot_h_q < cfg.min_height)) begin
						done_q  <= 1'b1;
						px_q    <= '0;
						py_q    <= '0;
						pw_q    <= base_w_q;
						ph_q    <= base_h_q;
						fits_q  <= 1'b0;
						full_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						gen_done_q <= 1'b0;
						found_q    <= 1'b0;
						inflight_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					inflight_q <= inflight_q + FW'(issue) - FW'(cand_out.valid);
					if (free_hit) begin
						found_q <= 1'b1;
					end
					if (issue && !x_fit && !y_fit) begin
						gen_done_q <= 1'b1;
					end
					if (scan_end) begin
						if (found_q) begin
							done_q  <= 1'b1;
							px_q    <= fx_q;
							py_q    <= fy_q;
							pw_q    <= try_w_q;
							ph_q    <= try_h_q;
							fits_q  <= 1'b1;
							full_q  <= full;
							state_q <= ST_IDLE;
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
						end else if (pct_q == PCT_LAST) begin
							done_q  <= 1'b1;
							px_q    <= '0;
							py_q    <= '0;
							pw_q    <= base_w_q;
							ph_q    <= base_h_q;
							fits_q  <= 1'b0;
							full_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							pct_q   <= pct_q - PCT_STEP;
							state_q <= ST_MUL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sizing, grid walk and found spot
	always_ff @(posedge clk) begin
		if (accept && (op == OP_PLACE)) begin
			base_w_q <= clamp_w;
			base_h_q <= clamp_h;
		end
		prod_w_q <= PROD_W'(base_w_q) * PROD_W'(pct_q);
		prod_h_q <= PROD_W'(base_h_q) * PROD_W'(pct_q);
		quot_w_q <= quot_w_full[DIV_SHIFT +: DIM_W];
		quot_h_q <= quot_h_full[DIV_SHIFT +: DIM_W];
		if (state_q == ST_CHECK) begin
			try_w_q <= quot_w_q;
			try_h_q <= quot_h_q;
			gx_q    <= '0;
			gy_q    <= '0;
		end else if (issue) begin
			if (x_fit) begin
				gx_q <= nx[DIM_W-1:0];
			end else if (y_fit) begin
				gx_q <= '0;
				gy_q <= ny[DIM_W-1:0];
			end
		end
		if (free_hit) begin
			fx_q <= cand_out.x;
			fy_q <= cand_out.y;
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign place_x      = px_q;
	assign place_y      = py_q;
	assign place_width  = pw_q;
	assign place_height = ph_q;
	assign fits         = fits_q;
	assign table_full   = full_q;
	assign done         = done_q;

endmodule

@@ hw/rtl/first_fit_window_placer.sv @@
// channel   direction  transfer edge          payload
// command   in         start && !busy         op, rect_x, rect_y, rect_width, rect_height
// result    out        done (one cycle)       place_x, place_y, place_width, place_height,
//                                             fits, table_full
// config    in         cfg_valid && cfg_ready cfg_index, cfg_data
//
// clear and add take effect in the accept cycle; an add to a full table reports in the
// cycle after. a place request runs, per size try, the multiply, divide and check states,
// then issues grid spots into the cell row until the first free spot leaves it, and waits
// for the row to drain; at most seven tries. the cell row checks one spot per cycle.
// reset clears the table count and loads the register defaults; table entries are not
// cleared. busy is high while a place request runs; results cannot be stalled.
module first_fit_window_placer
	import ffwp_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                op,
	input  logic signed [FIELD_W-1:0] rect_x,
	input  logic signed [FIELD_W-1:0] rect_y,
	input  logic [FIELD_W-1:0]        rect_width,
	input  logic [FIELD_W-1:0]        rect_height,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [DIM_W-1:0]          cfg_data,
	output logic                      done,
	output logic [DIM_W-1:0]          place_x,
	output logic [DIM_W-1:0]          place_y,
	output logic [DIM_W-1:0]          place_width,
	output logic [DIM_W-1:0]          place_height,
	output logic                      fits,
	output logic                      table_full
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	ffwp_cfg_t        cfg_q;
	ffwp_wr_t         wr;
	logic [IW-1:0]    wr_idx;
	logic [CW-1:0]    count;
	logic [DIM_W-1:0] try_w, try_h;
	ffwp_cand_t       cand [0:TABLE_DEPTH];

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= SCREEN_W_RST;
			cfg_q.screen_height <= SCREEN_H_RST;
			cfg_q.min_width     <= MIN_W_RST;
			cfg_q.min_height    <= MIN_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SCREEN_W: cfg_q.screen_width  <= cfg_data;
				CFG_SCREEN_H: cfg_q.screen_height <= cfg_data;
				CFG_MIN_W:    cfg_q.min_width     <= cfg_data;
				CFG_MIN_H:    cfg_q.min_height    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	ffwp_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.cfg         (cfg_q),
		.busy        (busy),
		.wr          (wr),
		.wr_idx      (wr_idx),
		.count       (count),
		.try_w       (try_w),
		.try_h       (try_h),
		.cand_in     (cand[0]),
		.cand_out    (cand[TABLE_DEPTH]),
		.place_x     (place_x),
		.place_y     (place_y),
		.place_width (place_width),
		.place_height(place_height),
		.fits        (fits),
		.table_full  (table_full),
		.done        (done)
	);

	// row of table cells, one stored rectangle each
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		ffwp_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.IDX        (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.wr_idx  (wr_idx),
			.count   (count),
			.try_w   (try_w),
			.try_h   (try_h),
			.cand_in (cand[k]),
			.cand_out(cand[k+1])
		);
	end

endmodule

@@ hw/rtl/ffwp_checker.sv @@
module ffwp_checker
	import ffwp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [1:0]       op,
	input logic             done,
	input logic [DIM_W-1:0] place_x,
	input logic [DIM_W-1:0] place_y,
	input logic [DIM_W-1:0] place_width,
	input logic [DIM_W-1:0] place_height,
	input logic             fits,
	input logic             table_full
);

	// a result only follows a command transfer or a running request
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without a preceding command");

	// a failed result, from a search or a rejected add, reports the origin
	a_fail_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !fits) |-> (place_x == '0 && place_y == '0))
		else $error("failed result with nonzero position");

	// a rejected add carries no size
	a_full_add_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !fits && table_full) |-> (place_width == '0 && place_height == '0))
		else $error("rejected add with nonzero size");

	// a place transfer starts a busy period
	a_place_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_PLACE) |=> busy)
		else $error("place request did not raise busy");

endmodule

bind first_fit_window_placer ffwp_checker u_ffwp_checker (.*);

@@ verif/first_fit_window_placer_tb.sv @@
module first_fit_window_placer_tb;
	import ffwp_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// a full failed search at the default screen is about 30k spots
	localparam int STALL_LIMIT = 200000;
	localparam int RANDOM_PHASES = 8;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        w;
		logic [15:0]        h;
	} command_t;

	typedef struct packed {
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic             fits;
		logic             table_full;
	} placement_t;

	typedef struct packed {
		logic        found;
		logic [15:0] x;
		logic [15:0] y;
	} spot_t;

	typedef struct packed {
		command_t   cmd;
		logic [4:0] reps;
		logic       given;
		placement_t want;
	} directed_row_t;

	localparam placement_t NO_RESULT = '0;
	localparam int DIRECTED_ROWS = 14;

	// directed rows, run at the reset register values
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// window below the minimum size on the first try
		'{'{OP_PLACE, 16'sd0, 16'sd0, 16'd100, 16'd100}, 5'd1, 1'b1,
			'{13'd0, 13'd0, 13'd100, 13'd100, 1'b0, 1'b0}},
		// oversize window clamped to the screen, fits at the origin
		'{'{OP_PLACE, 16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF}, 5'd1, 1'b1,
			'{13'd0, 13'd0, 13'd1920, 13'd1080, 1'b1, 1'b0}},
		// screen fully covered, every shrink step fails
		'{'{OP_PLACE, 16'sd0, 16'sd0, 16'd1920, 16'd1080}, 5'd1, 1'b1,
			'{13'd0, 13'd0, 13'd1920, 13'd1080, 1'b0, 1'b0}},
		// unused code is ignored
		'{'{OP_UNUSED, -16'sd1, -16'sd1, 16'hFFFF, 16'hFFFF}, 5'd1, 1'b0, NO_RESULT},
		'{'{OP_CLEAR, 16'sd0, 16'sd0, 16'd0, 16'd0}, 5'd1, 1'b0, NO_RESULT},
		// extreme corners, zero-size and wrapping rectangles
		'{'{OP_ADD, 16'sh8000, 16'sh8000, 16'd0, 16'd0}, 5'd1, 1'b0, NO_RESULT},
		'{'{OP_ADD, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF}, 5'd1, 1'b0, NO_RESULT},
		// top-left quarter taken
		'{'{OP_ADD, 16'sd0, 16'sd0, 16'd960, 16'd540}, 5'd1, 1'b0, NO_RESULT},
		'{'{OP_PLACE, 16'sd0, 16'sd0, 16'd960, 16'd1080}, 5'd1, 1'b0, NO_RESULT},
		// fill the table with rectangles that just touch the origin
		'{'{OP_ADD, -16'sd8, -16'sd8, 16'd8, 16'd8}, 5'd12, 1'b0, NO_RESULT},
		// add to a full table
		'{'{OP_ADD, 16'sd0, 16'sd0, 16'd100, 16'd100}, 5'd1, 1'b1,
			'{13'd0, 13'd0, 13'd0, 13'd0, 1'b0, 1'b1}},
		// success with a full table, not stored, so the repeat lands on the same spot
		'{'{OP_PLACE, 16'sd0, 16'sd0, 16'd960, 16'd540}, 5'd2, 1'b0, NO_RESULT},
		// zero-size window under the default minimum
		'{'{OP_PLACE, 16'sd0, 16'sd0, 16'd0, 16'd0}, 5'd1, 1'b1,
			'{13'd0, 13'd0, 13'd0, 13'd0, 1'b0, 1'b0}},
		'{'{OP_CLEAR, 16'sd0, 16'sd0, 16'd0, 16'd0}, 5'd1, 1'b0, NO_RESULT}
	};

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [1:0]                op = OP_CLEAR;
	logic signed [FIELD_W-1:0] rect_x = '0;
	logic signed [FIELD_W-1:0] rect_y = '0;
	logic [FIELD_W-1:0]        rect_width = '0;
	logic [FIELD_W-1:0]        rect_height = '0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [1:0]                cfg_index = CFG_SCREEN_W;
	logic [DIM_W-1:0]          cfg_data = '0;
	logic                      done;
	logic [DIM_W-1:0]          place_x;
	logic [DIM_W-1:0]          place_y;
	logic [DIM_W-1:0]          place_width;
	logic [DIM_W-1:0]          place_height;
	logic                      fits;
	logic                      table_full;

	// predictor state
	ffwp_cfg_t   placer_cfg;
	ffwp_entry_t occupied [DEPTH];
	int          occupied_count;

	placement_t pending_placements[$];
	int         mismatch_count = 0;
	int         result_count = 0;
	bit         burst_mode = 1'b0;

	first_fit_window_placer #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.place_x(place_x),
		.place_y(place_y),
		.place_width(place_width),
		.place_height(place_height),
		.fits(fits),
		.table_full(table_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// half-open overlap against every stored rectangle
	function automatic bit overlaps_any(input int x, input int y, input int w, input int h);
		int ax, ay, aw, ah;
		for (int k = 0; k < occupied_count && k < DEPTH; k++) begin
			ax = $signed(occupied[k].left);
			ay = $signed(occupied[k].top);
			aw = occupied[k].width;
			ah = occupied[k].height;
			if (x < ax + aw && ax < x + w && y < ay + ah && ay < y + h) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// row by row grid scan for the first free spot
	function automatic spot_t first_free_spot(input int w, input int h, input int sw,
			input int sh);
		spot_t s;
		s = '0;
		for (int y = 0; y + h <= sh; y += GRID_STEP) begin
			for (int x = 0; x + w <= sw; x += GRID_STEP) begin
				if (!overlaps_any(x, y, w, h)) begin
					s.found = 1'b1;
					s.x = 16'(x);
					s.y = 16'(y);
					return s;
				end
			end
		end
		return s;
	endfunction

	task automatic store_rect(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] w, input logic [15:0] h);
		occupied[occupied_count].left = x;
		occupied[occupied_count].top = y;
		occupied[occupied_count].width = w;
		occupied[occupied_count].height = h;
		occupied_count++;
	endtask

	// expected outcome of one command, updating the predicted table
	task automatic compute_placement(input command_t c, output bit produces,
			output placement_t res);
		int sw, sh, mw, mh, w, h, tw, th, pct;
		bit found, stop;
		spot_t s;
		res = '0;
		produces = 1'b0;
		sw = placer_cfg.screen_width;
		sh = placer_cfg.screen_height;
		mw = placer_cfg.min_width;
		mh = placer_cfg.min_height;
		case (c.op)
			OP_CLEAR: occupied_count = 0;
			OP_ADD: begin
				if (occupied_count < DEPTH) begin
					store_rect(c.x, c.y, c.w, c.h);
				end else begin
					res.table_full = 1'b1;
					produces = 1'b1;
				end
			end
			OP_PLACE: begin
				w = c.w;
				h = c.h;
				if (w > sw) w = sw;
				if (h > sh) h = sh;
				found = 1'b0;
				stop = 1'b0;
				s = '0;
				// shrink in 10 percent steps down to 40 percent
				for (pct = 100; pct >= 40 && !found && !stop; pct -= 10) begin
					tw = w * pct / 100;
					th = h * pct / 100;
					if (tw < mw || th < mh) begin
						stop = 1'b1;
					end else begin
						s = first_free_spot(tw, th, sw, sh);
						if (s.found) begin
							w = tw;
							h = th;
							found = 1'b1;
						end
					end
				end
				produces = 1'b1;
				res.x = found ? s.x[DIM_W-1:0] : '0;
				res.y = found ? s.y[DIM_W-1:0] : '0;
				res.w = w[DIM_W-1:0];
				res.h = h[DIM_W-1:0];
				res.fits = found;
				if (found) begin
					if (occupied_count < DEPTH) begin
						store_rect(s.x, s.y, w[15:0], h[15:0]);
					end else begin
						res.table_full = 1'b1;
					end
				end
			end
			default: ;
		endcase
	endtask

	// one command transfer; start drops only when a gap follows or the command is the last
	task automatic issue_command(input command_t c, input bit given, input placement_t want,
			input bit last);
		int gap;
		bit produces;
		placement_t predicted;
		start <= 1'b1;
		op <= c.op;
		rect_x <= c.x;
		rect_y <= c.y;
		rect_width <= c.w;
		rect_height <= c.h;
		do @(posedge clk); while (busy);
		compute_placement(c, produces, predicted);
		if (given) begin
			pending_placements.push_back(want);
		end else if (produces) begin
			pending_placements.push_back(predicted);
		end
		gap = burst_mode ? 0 : $urandom_range(0, 14);
		if (last || gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_register(input ffwp_cfg_idx_t idx, input logic [DIM_W-1:0] value,
			input bit last);
		int gap;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SCREEN_W: placer_cfg.screen_width = value;
			CFG_SCREEN_H: placer_cfg.screen_height = value;
			CFG_MIN_W:    placer_cfg.min_width = value;
			CFG_MIN_H:    placer_cfg.min_height = value;
		endcase
		gap = burst_mode ? 0 : $urandom_range(0, 14);
		if (last || gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every placement, then let the cell row drain
	task automatic drain_results();
		while (pending_placements.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	// small screens keep scans short; extremes come in the first two phases
	task automatic configure_phase(input int phase);
		ffwp_cfg_t setting;
		case (phase)
			0: setting = '{13'd8191, 13'd8191, 13'd8191, 13'd8191};
			1: setting = '{13'd1, 13'd1, 13'd0, 13'd0};
			default: begin
				setting.screen_width = 13'($urandom_range(1, 256));
				setting.screen_height = 13'($urandom_range(1, 256));
				setting.min_width = 13'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
					: $urandom_range(0, setting.screen_width / 2));
				setting.min_height = 13'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
					: $urandom_range(0, setting.screen_height / 2));
			end
		endcase
		write_register(CFG_SCREEN_W, setting.screen_width, 1'b0);
		write_register(CFG_SCREEN_H, setting.screen_height, 1'b0);
		write_register(CFG_MIN_W, setting.min_width, 1'b0);
		write_register(CFG_MIN_H, setting.min_height, 1'b1);
	endtask

	// mostly on-screen rectangles and screen-sized windows, some noise
	function automatic command_t draw_command();
		command_t c;
		int sw, sh, kind;
		sw = placer_cfg.screen_width;
		sh = placer_cfg.screen_height;
		c = '0;
		kind = $urandom_range(0, 99);
		if (kind < 5) begin
			c.op = OP_CLEAR;
		end else if (kind < 8) begin
			c.op = OP_UNUSED;
			c.x = 16'($urandom);
			c.y = 16'($urandom);
			c.w = 16'($urandom);
			c.h = 16'($urandom);
		end else if (kind < 50) begin
			c.op = OP_ADD;
			if ($urandom_range(0, 4) == 0) begin
				c.x = 16'($urandom);
				c.y = 16'($urandom);
				c.w = 16'($urandom);
				c.h = 16'($urandom);
			end else begin
				c.x = 16'($urandom_range(0, sw + 16) - 8);
				c.y = 16'($urandom_range(0, sh + 16) - 8);
				c.w = 16'($urandom_range(0, sw / 2 + 8));
				c.h = 16'($urandom_range(0, sh / 2 + 8));
			end
		end else begin
			c.op = OP_PLACE;
			case ($urandom_range(0, 9))
				0, 1: begin
					c.w = 16'($urandom);
					c.h = 16'($urandom);
				end
				2: begin
					c.w = '0;
					c.h = 16'($urandom_range(0, 2));
				end
				default: begin
					c.w = 16'($urandom_range(0, sw + 16));
					c.h = 16'($urandom_range(0, sh + 16));
				end
			endcase
		end
		return c;
	endfunction

	// result check against the oldest expected placement
	always @(posedge clk) begin
		placement_t got;
		placement_t want;
		if (arst_n && done) begin
			got = {place_x, place_y, place_width, place_height, fits, table_full};
			result_count++;
			if (pending_placements.size() == 0) begin
				note_mismatch($sformatf("result %0d with no command waiting", result_count));
			end else begin
				want = pending_placements.pop_front();
				if (got.x != want.x)
					note_mismatch($sformatf("result %0d place_x %0d, expected %0d",
						result_count, got.x, want.x));
				if (got.y != want.y)
					note_mismatch($sformatf("result %0d place_y %0d, expected %0d",
						result_count, got.y, want.y));
				if (got.w != want.w)
					note_mismatch($sformatf("result %0d place_width %0d, expected %0d",
						result_count, got.w, want.w));
				if (got.h != want.h)
					note_mismatch($sformatf("result %0d place_height %0d, expected %0d",
						result_count, got.h, want.h));
				if (got.fits !== want.fits)
					note_mismatch($sformatf("result %0d fits %b, expected %b",
						result_count, got.fits, want.fits));
				if (got.table_full !== want.table_full)
					note_mismatch($sformatf("result %0d table_full %b, expected %b",
						result_count, got.table_full, want.table_full));
			end
		end
	end

	// watchdog on cycles with no transfer on any channel
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("first_fit_window_placer regression: fail");
		$finish;
	end

	initial begin : stimulus
		int r, i, n, phase;
		placer_cfg = '{SCREEN_W_RST, SCREEN_H_RST, MIN_W_RST, MIN_H_RST};
		occupied_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows
		for (r = 0; r < DIRECTED_ROWS; r++) begin
			for (i = 0; i < directed_rows[r].reps; i++) begin
				issue_command(directed_rows[r].cmd, directed_rows[r].given,
					directed_rows[r].want,
					r == DIRECTED_ROWS - 1 && i == directed_rows[r].reps - 1);
			end
		end

		// random phases, each under a new register setting
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			burst_mode = (phase == 1) || ($urandom_range(0, 2) == 0);
			configure_phase(phase);
			n = $urandom_range(8, 11);
			for (i = 0; i < n; i++) begin
				issue_command(draw_command(), 1'b0, NO_RESULT, i == n - 1);
			end
		end

		drain_results();
		if (mismatch_count == 0)
			$display("first_fit_window_placer regression: pass");
		else
			$display("first_fit_window_placer regression: fail");
		$finish;
	end

endmodule
